[rtl/core/psvb_pkg.sv]
// Shared types, constants and note tables for the polyphonic sine voice bank.
package psvb_pkg;

    localparam int VOICES_DEF     = 32;
    localparam int SINE_DEPTH_DEF = 1024;

    localparam int ISR_W    = 28;
    localparam int ATT_W    = 16;
    localparam int NOTE_W   = 7;
    localparam int VEL_W    = 7;
    localparam int SAMPLE_W = 24;
    localparam int COUNT_W  = 6;
    localparam int PHASE_W  = 32;
    localparam int ENV_W    = 16;
    localparam int FREQ_W   = 30;
    localparam int GAIN_W   = 19;
    localparam int SINE_W   = 16;
    localparam int OCT_W    = 4;

    localparam logic [ISR_W-1:0]  ISR_RESET = 28'd24932236;
    localparam logic [ATT_W-1:0]  ATT_RESET = 16'd66;
    localparam logic [GAIN_W-1:0] MIX_GAIN  = 19'd422733;
    localparam int                MIX_SHIFT = 40;

    typedef enum logic [1:0] {
        MODE_NOTE_ON  = 2'd0,
        MODE_NOTE_OFF = 2'd1,
        MODE_TICK     = 2'd2
    } mode_t;

    typedef enum logic {
        CFG_INV_RATE = 1'b0,
        CFG_ATTACK   = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } seq_state_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [ENV_W-1:0]   envelope;
    } voice_word_t;

    // Octave of a MIDI note, that is note / 12, by threshold compares.
    function automatic logic [OCT_W-1:0] note_octave(input logic [NOTE_W-1:0] note);
        logic [OCT_W-1:0] oct;
        oct = '0;
        for (int k = 1; k <= 10; k++) begin
            if (note >= NOTE_W'(12 * k)) begin
                oct = OCT_W'(k);
            end
        end
        return oct;
    endfunction

    // Pitch class of a MIDI note given its octave.
    function automatic logic [3:0] note_class(input logic [NOTE_W-1:0] note,
                                              input logic [OCT_W-1:0]  oct);
        logic [NOTE_W-1:0] base;
        base = NOTE_W'({3'b000, oct} * NOTE_W'(12));
        return 4'(note - base);
    endfunction

    // Frequencies of notes 120 to 131 in Q14.16.
    function automatic logic [FREQ_W-1:0] freq_top(input logic [3:0] pc);
        logic [FREQ_W-1:0] f;
        case (pc)
            4'd0:    f = 30'd548668578;
            4'd1:    f = 30'd581294109;
            4'd2:    f = 30'd615859655;
            4'd3:    f = 30'd652480576;
            4'd4:    f = 30'd691279090;
            4'd5:    f = 30'd732384684;
            4'd6:    f = 30'd775934544;
            4'd7:    f = 30'd822074013;
            4'd8:    f = 30'd870957077;
            4'd9:    f = 30'd922746880;
            4'd10:   f = 30'd977616265;
            4'd11:   f = 30'd1035748353;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

[rtl/core/polyphonic_sine_voice_bank.sv]
// Top level of the polyphonic sine voice bank: voice allocation, tick sequencer and mix pipeline.
//
//   Channel  Direction  Handshake           Payload
//   s_       in         s_valid / s_ready   s_mode, s_note, s_velocity
//   m_       out        m_valid / m_ready   m_sample, m_voices_in_use
//   cfg_     in         cfg_wr_en           cfg_index, cfg_wdata
//
// A note-on or note-off beat is absorbed as soon as it is accepted. A tick beat walks every
// voice through the state memory, one voice per cycle, and its result is registered once the
// last voice leaves the eight-stage mix pipeline. The input takes no beat while a tick is in
// flight, nor a tick while a result still waits.
// Reset loads the configuration defaults and clears every active flag; no clearing pass is needed.
module polyphonic_sine_voice_bank #(
    parameter int VOICES     = psvb_pkg::VOICES_DEF,
    parameter int SINE_DEPTH = psvb_pkg::SINE_DEPTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_mode,
    input  logic [psvb_pkg::NOTE_W-1:0]          s_note,
    input  logic [psvb_pkg::VEL_W-1:0]           s_velocity,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [psvb_pkg::SAMPLE_W-1:0] m_sample,
    output logic [psvb_pkg::COUNT_W-1:0]         m_voices_in_use,
    input  logic                                 cfg_wr_en,
    input  logic                                 cfg_index,
    input  logic [psvb_pkg::ISR_W-1:0]           cfg_wdata
);
    import psvb_pkg::*;

    localparam int IDXW  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SW    = $clog2(SINE_DEPTH);
    localparam int PLO_W = FREQ_W + 14;
    localparam int PRD_W = FREQ_W + ISR_W;
    localparam int VG_W  = VEL_W + GAIN_W;
    localparam int SE_W  = (SINE_W - 1) + ENV_W;
    localparam int MAG_W = SE_W + VG_W;
    localparam int ACC_W = SAMPLE_W + 8;
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(VOICES - 1);

    // Configuration registers.
    logic [ISR_W-1:0] isr_reg;
    logic [ATT_W-1:0] att_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            isr_reg <= ISR_RESET;
            att_reg <= ATT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_INV_RATE: isr_reg <= cfg_wdata;
                CFG_ATTACK:   att_reg <= cfg_wdata[ATT_W-1:0];
                default:      ;
            endcase
        end
    end

    // Sequencer.
    seq_state_t      state_reg, state_next;
    logic [IDXW-1:0] cnt_reg;
    logic            issue;
    logic            s_fire;
    logic            tick_fire;
    logic            last_done;
    logic            m_valid_reg;

    assign s_ready   = (state_reg == ST_IDLE) && !((s_mode == MODE_TICK) && m_valid_reg);
    assign s_fire    = s_valid && s_ready;
    assign tick_fire = s_fire && (s_mode == MODE_TICK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= issue ? cnt_reg + IDXW'(1) : '0;
        end
    end

    always_comb begin
        state_next = state_reg;
        issue      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (tick_fire) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                issue = 1'b1;
                if (cnt_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (last_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Voice table: active flags, notes and velocities. Phase and envelope live in memory.
    logic [VOICES-1:0] active_reg;
    logic [NOTE_W-1:0] note_reg [VOICES];
    logic [VEL_W-1:0]  vel_reg  [VOICES];
    logic              free_found;
    logic [IDXW-1:0]   free_idx;
    logic              do_on;
    logic              do_off;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int v = VOICES - 1; v >= 0; v--) begin
            if (!active_reg[v]) begin
                free_found = 1'b1;
                free_idx   = IDXW'(v);
            end
        end
    end

    assign do_on  = s_fire && (s_mode == MODE_NOTE_ON) && (s_velocity != '0) && free_found;
    assign do_off = s_fire && ((s_mode == MODE_NOTE_OFF) ||
                               ((s_mode == MODE_NOTE_ON) && (s_velocity == '0)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
        end else if (do_on) begin
            active_reg[free_idx] <= 1'b1;
        end else if (do_off) begin
            for (int v = 0; v < VOICES; v++) begin
                if (note_reg[v] == s_note) begin
                    active_reg[v] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_on) begin
            note_reg[free_idx] <= s_note;
            vel_reg[free_idx]  <= s_velocity;
        end
    end

    // Mix pipeline valid and last markers.
    logic [8:1] vld_reg;
    logic [8:1] last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            last_reg <= '0;
        end else begin
            vld_reg  <= {vld_reg[7:1], issue};
            last_reg <= {last_reg[7:1], issue && (cnt_reg == LAST_IDX)};
        end
    end

    assign last_done = vld_reg[8] && last_reg[8];

    // Stage 1: voice fields captured at the issue index.
    logic              p1_act_reg;
    logic [IDXW-1:0]   p1_idx_reg;
    logic [NOTE_W-1:0] p1_note_reg;
    logic [VEL_W-1:0]  p1_vel_reg;

    always_ff @(posedge aclk) begin
        p1_act_reg  <= active_reg[cnt_reg];
        p1_idx_reg  <= cnt_reg;
        p1_note_reg <= note_reg[cnt_reg];
        p1_vel_reg  <= vel_reg[cnt_reg];
    end

    // Stage 2: note frequency lookup, low partial product, velocity gain.
    logic [OCT_W-1:0]  p1_oct;
    logic [FREQ_W-1:0] p1_freq;
    logic              p2_act_reg;
    logic [IDXW-1:0]   p2_idx_reg;
    logic [OCT_W-1:0]  p2_oct_reg;
    logic [FREQ_W-1:0] p2_freq_reg;
    logic [PLO_W-1:0]  p2_plo_reg;
    logic [VG_W-1:0]   p2_vg_reg;

    assign p1_oct  = note_octave(p1_note_reg);
    assign p1_freq = freq_top(note_class(p1_note_reg, p1_oct));

    always_ff @(posedge aclk) begin
        p2_act_reg  <= p1_act_reg;
        p2_idx_reg  <= p1_idx_reg;
        p2_oct_reg  <= p1_oct;
        p2_freq_reg <= p1_freq;
        p2_plo_reg  <= PLO_W'(p1_freq) * PLO_W'(isr_reg[13:0]);
        p2_vg_reg   <= VG_W'(p1_vel_reg) * VG_W'(MIX_GAIN);
    end

    // Stage 3: high partial product.
    logic             p3_act_reg;
    logic [IDXW-1:0]  p3_idx_reg;
    logic [OCT_W-1:0] p3_oct_reg;
    logic [PLO_W-1:0] p3_plo_reg;
    logic [PLO_W-1:0] p3_phi_reg;
    logic [VG_W-1:0]  p3_vg_reg;

    always_ff @(posedge aclk) begin
        p3_act_reg <= p2_act_reg;
        p3_idx_reg <= p2_idx_reg;
        p3_oct_reg <= p2_oct_reg;
        p3_plo_reg <= p2_plo_reg;
        p3_phi_reg <= PLO_W'(p2_freq_reg) * PLO_W'(isr_reg[ISR_W-1:14]);
        p3_vg_reg  <= p2_vg_reg;
    end

    // Stage 4: combine partial products and scale by octave; memory read issued.
    logic [PRD_W-1:0]   p3_prod;
    logic [5:0]         p3_shift;
    logic               p4_act_reg;
    logic [IDXW-1:0]    p4_idx_reg;
    logic [PHASE_W-1:0] p4_step_reg;
    logic [VG_W-1:0]    p4_vg_reg;

    assign p3_prod  = PRD_W'(p3_plo_reg) + {p3_phi_reg, 14'b0};
    assign p3_shift = 6'd34 - 6'(p3_oct_reg);

    always_ff @(posedge aclk) begin
        p4_act_reg  <= p3_act_reg;
        p4_idx_reg  <= p3_idx_reg;
        p4_step_reg <= PHASE_W'(p3_prod >> p3_shift);
        p4_vg_reg   <= p3_vg_reg;
    end

    // Stage 5: phase advance and envelope ramp, written back to memory.
    voice_word_t        rd_word;
    voice_word_t        wr_word;
    logic               mem_we;
    logic [IDXW-1:0]    mem_waddr;
    logic [PHASE_W-1:0] p4_phase;
    logic [ENV_W:0]     p4_env_sum;
    logic [ENV_W-1:0]   p4_env;

    assign p4_phase   = rd_word.phase + p4_step_reg;
    assign p4_env_sum = {1'b0, rd_word.envelope} + {1'b0, att_reg};
    assign p4_env     = p4_env_sum[ENV_W] ? '1 : p4_env_sum[ENV_W-1:0];

    // Note-on and tick write-back never coincide: note-on is taken only while idle.
    always_comb begin
        if (do_on) begin
            mem_we    = 1'b1;
            mem_waddr = free_idx;
            wr_word   = '0;
        end else begin
            mem_we           = vld_reg[4] && p4_act_reg;
            mem_waddr        = p4_idx_reg;
            wr_word.phase    = p4_phase;
            wr_word.envelope = p4_env;
        end
    end

    psvb_state_mem #(
        .VOICES (VOICES)
    ) u_state_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (wr_word),
        .rd_addr (p3_idx_reg),
        .rd_data (rd_word)
    );

    logic             p5_act_reg;
    logic [SW-1:0]    p5_sidx_reg;
    logic [ENV_W-1:0] p5_env_reg;
    logic [VG_W-1:0]  p5_vg_reg;

    always_ff @(posedge aclk) begin
        p5_act_reg  <= p4_act_reg;
        p5_sidx_reg <= p4_phase[PHASE_W-1 -: SW];
        p5_env_reg  <= p4_env;
        p5_vg_reg   <= p4_vg_reg;
    end

    // Stage 6: sine lookup.
    logic signed [SINE_W-1:0] p6_sine;
    logic                     p6_act_reg;
    logic [ENV_W-1:0]         p6_env_reg;
    logic [VG_W-1:0]          p6_vg_reg;

    psvb_sine_rom #(
        .DEPTH (SINE_DEPTH)
    ) u_sine_rom (
        .aclk (aclk),
        .addr (p5_sidx_reg),
        .data (p6_sine)
    );

    always_ff @(posedge aclk) begin
        p6_act_reg <= p5_act_reg;
        p6_env_reg <= p5_env_reg;
        p6_vg_reg  <= p5_vg_reg;
    end

    // Stage 7: sine magnitude times envelope.
    logic [SINE_W-1:0] p6_abs;
    logic              p7_act_reg;
    logic              p7_neg_reg;
    logic [SE_W-1:0]   p7_se_reg;
    logic [VG_W-1:0]   p7_vg_reg;

    assign p6_abs = p6_sine[SINE_W-1] ? SINE_W'(-p6_sine) : SINE_W'(p6_sine);

    always_ff @(posedge aclk) begin
        p7_act_reg <= p6_act_reg;
        p7_neg_reg <= p6_sine[SINE_W-1];
        p7_se_reg  <= SE_W'(p6_abs[SINE_W-2:0]) * SE_W'(p6_env_reg);
        p7_vg_reg  <= p6_vg_reg;
    end

    // Stage 8: times velocity gain.
    logic             p8_act_reg;
    logic             p8_neg_reg;
    logic [MAG_W-1:0] p8_mag_reg;

    always_ff @(posedge aclk) begin
        p8_act_reg <= p7_act_reg;
        p8_neg_reg <= p7_neg_reg;
        p8_mag_reg <= MAG_W'(p7_se_reg) * MAG_W'(p7_vg_reg);
    end

    // Stage 9: round half away from zero, accumulate, and saturate on the last voice.
    logic [MAG_W-1:0]         p8_round;
    logic signed [ACC_W-1:0]  p8_term;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [COUNT_W-1:0]       count_reg, count_next;
    logic signed [SAMPLE_W-1:0] sat_sample;
    logic signed [SAMPLE_W-1:0] m_sample_reg;
    logic [COUNT_W-1:0]       m_count_reg;

    assign p8_round = p8_mag_reg + (MAG_W'(1) << (MIX_SHIFT - 1));
    assign p8_term  = p8_neg_reg ? -ACC_W'(p8_round[MAG_W-1:MIX_SHIFT])
                                 :  ACC_W'(p8_round[MAG_W-1:MIX_SHIFT]);

    always_comb begin
        acc_next   = acc_reg;
        count_next = count_reg;
        if (vld_reg[8] && p8_act_reg) begin
            acc_next   = acc_reg + p8_term;
            count_next = count_reg + COUNT_W'(1);
        end
        if (acc_next > ACC_W'(signed'((1 << (SAMPLE_W - 1)) - 1))) begin
            sat_sample = {1'b0, {(SAMPLE_W - 1){1'b1}}};
        end else if (acc_next < -ACC_W'(signed'(1 << (SAMPLE_W - 1)))) begin
            sat_sample = {1'b1, {(SAMPLE_W - 1){1'b0}}};
        end else begin
            sat_sample = SAMPLE_W'(acc_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (tick_fire) begin
                acc_reg   <= '0;
                count_reg <= '0;
            end else begin
                acc_reg   <= acc_next;
                count_reg <= count_next;
            end
            if (last_done) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (last_done) begin
            m_sample_reg <= sat_sample;
            m_count_reg  <= count_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_sample        = m_sample_reg;
    assign m_voices_in_use = m_count_reg;

endmodule

[rtl/core/psvb_sine_rom.sv]
// Full-wave sine ROM in Q1.15 with a registered read port.
module psvb_sine_rom #(
    parameter int DEPTH = psvb_pkg::SINE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic [$clog2(DEPTH)-1:0]          addr,
    output logic signed [psvb_pkg::SINE_W-1:0] data
);
    import psvb_pkg::*;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic signed [SINE_W-1:0] rom_t [DEPTH];

    // Taylor series of sin(t) for t in Q30 radians over the first quadrant.
    function automatic longint unsigned quarter_sine(input longint unsigned t);
        longint unsigned t2;
        longint unsigned term;
        longint          sum;
        t2   = (t * t) >> 30;
        term = t;
        sum  = longint'(t);
        term = ((term * t2) >> 30) / 64'd6;
        sum  = sum - longint'(term);
        term = ((term * t2) >> 30) / 64'd20;
        sum  = sum + longint'(term);
        term = ((term * t2) >> 30) / 64'd42;
        sum  = sum - longint'(term);
        term = ((term * t2) >> 30) / 64'd72;
        sum  = sum + longint'(term);
        return (sum < 0) ? 64'd0 : longint'(sum);
    endfunction

    function automatic rom_t build_rom();
        rom_t            r;
        longint unsigned n4;
        longint unsigned q;
        longint unsigned rem;
        longint unsigned x;
        longint unsigned theta;
        longint unsigned v;
        for (int i = 0; i < DEPTH; i++) begin
            n4    = 64'(4 * i);
            q     = n4 / DEPTH;
            rem   = n4 - q * DEPTH;
            x     = q[0] ? (64'(DEPTH) - rem) : rem;
            theta = (HALF_PI_Q30 * x) / DEPTH;
            v     = (quarter_sine(theta) + 64'd16384) >> 15;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            r[i] = (q >= 64'd2) ? -SINE_W'(v) : SINE_W'(v);
        end
        return r;
    endfunction

    localparam rom_t ROM = build_rom();

    logic signed [SINE_W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        data_reg <= ROM[addr];
    end

    assign data = data_reg;

endmodule

[rtl/core/psvb_state_mem.sv]
// Per-voice phase and envelope store: one write port, one registered read port.
module psvb_state_mem #(
    parameter int VOICES = psvb_pkg::VOICES_DEF
) (
    input  logic                                         aclk,
    input  logic                                         wr_en,
    input  logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] wr_addr,
    input  psvb_pkg::voice_word_t                        wr_data,
    input  logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] rd_addr,
    output psvb_pkg::voice_word_t                        rd_data
);
    import psvb_pkg::*;

    voice_word_t mem [VOICES];
    voice_word_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
